// ===== hw/rtl/rotated_box_extents_top_macros.svh =====
// assertion macros shared by the block's checker
`ifndef ROTATED_BOX_EXTENTS_TOP_MACROS_SVH
`define ROTATED_BOX_EXTENTS_TOP_MACROS_SVH

// same-cycle implication, ignored while in reset
`define RBE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotated box extents check failed");

// next-cycle implication, ignored while in reset
`define RBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotated box extents check failed");

`endif

// ===== hw/rtl/rbe_pkg.sv =====
// shared constants for the rotated box extents block
package rbe_pkg;

    // rotation registers are signed q1.frac, fixed width
    localparam int TRIG_WIDTH = 16;

    // configuration register index
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_ANGLE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_ANGLE = 2'd1;

    // register reset values
    localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 16'sd32767;
    localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET = 16'sd0;

endpackage

// ===== hw/rtl/rotated_box_extents_top.sv =====
// rotated bounding box extents: top level
// path: a vertex marked last goes through stages 1, 2 and 3 and the output register
// throughput: one vertex per cycle while vertex_stall is low; a new vertex is taken while
// a result waits, set by the min/max tracker loop and the one multiply stage
// reset: rst_n asynchronous active low; cos_angle to 32767, sin_angle to 0,
// trackers to their empty values and all stages empty
module rotated_box_extents_top #(
    parameter int COORD_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rbe_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [rbe_pkg::TRIG_WIDTH-1:0]         cfg_data,

    // vertex channel
    input  logic                                   vertex_valid,
    output logic                                   vertex_stall,
    input  logic signed [COORD_WIDTH-1:0]          x_coord,
    input  logic signed [COORD_WIDTH-1:0]          y_coord,
    input  logic                                   last_vertex,

    // extents channel
    output logic                                   extent_valid,
    input  logic                                   extent_stall,
    output logic [COORD_WIDTH:0]                   minor_extent,
    output logic [COORD_WIDTH:0]                   major_extent
);

    // widths of the rotation datapath
    localparam int TW      = rbe_pkg::TRIG_WIDTH;
    localparam int PROD_W  = COORD_WIDTH + TW;       // one coordinate times one trig value
    localparam int SUM_W   = PROD_W + 1;             // sum of two products
    localparam int STATE_W = COORD_WIDTH + 1;        // tracked rotated coordinate

    // saturation bounds of the tracked range
    localparam logic signed [STATE_W-1:0] SAT_MAX = {1'b0, {COORD_WIDTH{1'b1}}};
    localparam logic signed [STATE_W-1:0] SAT_MIN = {1'b1, {COORD_WIDTH{1'b0}}};

    // clamp a scaled sum into the tracked range
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SUM_W-1:0] val
    );
        logic signed [STATE_W-1:0] res;
        begin
            if (val > SUM_W'(SAT_MAX))
            begin
                res = SAT_MAX;
            end
            else if (val < SUM_W'(SAT_MIN))
            begin
                res = SAT_MIN;
            end
            else
            begin
                res = STATE_W'(val);
            end
            return res;
        end
    endfunction

    // ---------------------------------------------------------------------
    // rotation registers, always ready for a write
    // ---------------------------------------------------------------------
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= rbe_pkg::COS_RESET;
            sin_reg <= rbe_pkg::SIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rbe_pkg::REG_COS_ANGLE: cos_reg <= cfg_data;
                rbe_pkg::REG_SIN_ANGLE: sin_reg <= cfg_data;
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // pipeline occupancy and flow control
    // each stage moves when the stage after it is empty or moving;
    // a vertex not marked last leaves stage 2 into the trackers at once,
    // so tracking goes on while a finished result waits at the output
    // ---------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic s1_last_reg;
    logic s2_last_reg;

    logic out_free;
    logic s3_go;
    logic s3_free;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic vertex_take;

    assign out_free    = !out_valid_reg || !extent_stall;
    assign s3_go       = s3_valid_reg && out_free;
    assign s3_free     = !s3_valid_reg || s3_go;
    assign s2_go       = s2_valid_reg && (!s2_last_reg || s3_free);
    assign s2_free     = !s2_valid_reg || s2_go;
    assign s1_go       = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s1_go;
    assign vertex_take = vertex_valid && s1_free;

    assign vertex_stall = !s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= vertex_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_go;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_go && s2_last_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_go;
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: registered vertex beat
    // ---------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] s1_x_reg;
    logic signed [COORD_WIDTH-1:0] s1_y_reg;

    always_ff @(posedge clk)
    begin
        if (vertex_take)
        begin
            s1_x_reg    <= x_coord;
            s1_y_reg    <= y_coord;
            s1_last_reg <= last_vertex;
        end
    end

    // ---------------------------------------------------------------------
    // rotation: four products, two sums, floor shift, saturation
    // u = floor((x*c + y*s) / 2^frac), v = floor((y*c - x*s) / 2^frac)
    // ---------------------------------------------------------------------
    logic signed [PROD_W-1:0]  prod_xc;
    logic signed [PROD_W-1:0]  prod_ys;
    logic signed [PROD_W-1:0]  prod_yc;
    logic signed [PROD_W-1:0]  prod_xs;
    logic signed [SUM_W-1:0]   sum_u;
    logic signed [SUM_W-1:0]   sum_v;
    logic signed [SUM_W-1:0]   scaled_u;
    logic signed [SUM_W-1:0]   scaled_v;
    logic signed [STATE_W-1:0] rot_u;
    logic signed [STATE_W-1:0] rot_v;

    always_comb
    begin
        prod_xc  = PROD_W'(s1_x_reg) * PROD_W'(cos_reg);
        prod_ys  = PROD_W'(s1_y_reg) * PROD_W'(sin_reg);
        prod_yc  = PROD_W'(s1_y_reg) * PROD_W'(cos_reg);
        prod_xs  = PROD_W'(s1_x_reg) * PROD_W'(sin_reg);
        sum_u    = SUM_W'(prod_xc) + SUM_W'(prod_ys);
        sum_v    = SUM_W'(prod_yc) - SUM_W'(prod_xs);
        // arithmetic shift rounds toward minus infinity
        scaled_u = sum_u >>> TRIG_FRAC_BITS;
        scaled_v = sum_v >>> TRIG_FRAC_BITS;
        rot_u    = sat_state(scaled_u);
        rot_v    = sat_state(scaled_v);
    end

    // ---------------------------------------------------------------------
    // stage 2: rotated vertex
    // ---------------------------------------------------------------------
    logic signed [STATE_W-1:0] s2_u_reg;
    logic signed [STATE_W-1:0] s2_v_reg;

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_u_reg    <= rot_u;
            s2_v_reg    <= rot_v;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------------
    // running min/max trackers; the last vertex is folded in before the
    // side lengths are taken, then the trackers go back to empty
    // ---------------------------------------------------------------------
    logic signed [STATE_W-1:0] min_u_reg;
    logic signed [STATE_W-1:0] max_u_reg;
    logic signed [STATE_W-1:0] min_v_reg;
    logic signed [STATE_W-1:0] max_v_reg;

    logic signed [STATE_W-1:0] min_u_upd;
    logic signed [STATE_W-1:0] max_u_upd;
    logic signed [STATE_W-1:0] min_v_upd;
    logic signed [STATE_W-1:0] max_v_upd;
    logic [STATE_W-1:0]        ext_u_next;
    logic [STATE_W-1:0]        ext_v_next;

    always_comb
    begin
        min_u_upd  = (s2_u_reg < min_u_reg) ? s2_u_reg : min_u_reg;
        max_u_upd  = (s2_u_reg > max_u_reg) ? s2_u_reg : max_u_reg;
        min_v_upd  = (s2_v_reg < min_v_reg) ? s2_v_reg : min_v_reg;
        max_v_upd  = (s2_v_reg > max_v_reg) ? s2_v_reg : max_v_reg;
        // side lengths wrap to the output width
        ext_u_next = STATE_W'(max_u_upd - min_u_upd);
        ext_v_next = STATE_W'(max_v_upd - min_v_upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_u_reg <= SAT_MAX;
            max_u_reg <= SAT_MIN;
            min_v_reg <= SAT_MAX;
            max_v_reg <= SAT_MIN;
        end
        else if (s2_go)
        begin
            if (s2_last_reg)
            begin
                min_u_reg <= SAT_MAX;
                max_u_reg <= SAT_MIN;
                min_v_reg <= SAT_MAX;
                max_v_reg <= SAT_MIN;
            end
            else
            begin
                min_u_reg <= min_u_upd;
                max_u_reg <= max_u_upd;
                min_v_reg <= min_v_upd;
                max_v_reg <= max_v_upd;
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: unsorted side lengths of a finished ring
    // ---------------------------------------------------------------------
    logic [STATE_W-1:0] s3_ext_u_reg;
    logic [STATE_W-1:0] s3_ext_v_reg;

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_last_reg && s3_free)
        begin
            s3_ext_u_reg <= ext_u_next;
            s3_ext_v_reg <= ext_v_next;
        end
    end

    // ---------------------------------------------------------------------
    // output register: sorted minor / major, held while stalled
    // ---------------------------------------------------------------------
    logic [STATE_W-1:0] minor_reg;
    logic [STATE_W-1:0] major_reg;
    logic               u_longer;

    assign u_longer = s3_ext_u_reg > s3_ext_v_reg;

    always_ff @(posedge clk)
    begin
        if (s3_go)
        begin
            minor_reg <= u_longer ? s3_ext_v_reg : s3_ext_u_reg;
            major_reg <= u_longer ? s3_ext_u_reg : s3_ext_v_reg;
        end
    end

    assign extent_valid = out_valid_reg;
    assign minor_extent = minor_reg;
    assign major_extent = major_reg;

endmodule

// ===== hw/rtl/rbe_checker.sv =====
// port-level checker for the rotated box extents block, with its bind
`include "rotated_box_extents_top_macros.svh"

module rbe_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_ready,
    input logic                 extent_valid,
    input logic                 extent_stall,
    input logic [COORD_WIDTH:0] minor_extent,
    input logic [COORD_WIDTH:0] major_extent
);

    // a stalled result beat stays put
    `RBE_ASSERT_NEXT(a_extent_hold, clk, rst_n, extent_valid && extent_stall, extent_valid && $stable(minor_extent) && $stable(major_extent))

    // extents leave sorted
    `RBE_ASSERT_IMPLIES(a_extent_sorted, clk, rst_n, extent_valid, minor_extent <= major_extent)

    // register writes are never held off
    `RBE_ASSERT_IMPLIES(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind rotated_box_extents_top rbe_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_rbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .extent_valid (extent_valid),
    .extent_stall (extent_stall),
    .minor_extent (minor_extent),
    .major_extent (major_extent)
);
